>>> rtl/core/ssp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants for the sorted slice point table
// Operation codes, status codes, value width and the command that the
// control logic broadcasts to every cell of the chain.
// ----------------------------------------------------------------------------
package ssp_pkg;

    // Q16 slice position, 65536 means 1.0
    localparam int unsigned VAL_W   = 17;
    localparam int unsigned POS_W   = 16;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned RIDX_W  = 7;
    localparam int unsigned CNT_W   = 8;
    localparam logic [VAL_W-1:0] Q16_ONE = VAL_W'(65536);

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SET    = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_CLOSE = 2'd2;
    localparam logic [1:0] ST_BAD   = 2'd3;

    // Command broadcast to all cells in the commit cycle
    typedef struct packed {
        logic             apply;
        op_t              op;
        logic             move_up;
        logic [VAL_W-1:0] value;
    } cell_cmd_t;

endpackage

>>> rtl/core/sorted_slice_point_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_slice_point_table: ascending table of Q16 slice points
// Add, remove, set and read on a sorted list held in a chain of cells.
// ----------------------------------------------------------------------------
// An item is accepted when start is high and busy is low. In the accept
// cycle every cell compares its point with the request and registers its
// flags; in the following cycle the flags are combined, the outcome is
// decided and the whole chain shifts by at most one place. busy is high
// during that decide cycle, and the result appears with done for one cycle
// right after it, at which point the next item may already be accepted.
// Results cannot be held off, so the receiver must take done whenever it comes.
// min_gap is written through cfg_valid/cfg_data, which is always ready and
// should only be written between items. Nothing needs clearing after reset.
// ----------------------------------------------------------------------------
module sorted_slice_point_table #(
    parameter int MAX_POINTS = 128
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   op,
    input  logic [ssp_pkg::POS_W-1:0]    position,
    input  logic                         position_over,
    input  logic [ssp_pkg::IDX_W-1:0]    entry_index,
    output logic                         done,
    output logic [1:0]                   status,
    output logic [ssp_pkg::RIDX_W-1:0]   result_index,
    output logic [ssp_pkg::VAL_W-1:0]    result_value,
    output logic [ssp_pkg::CNT_W-1:0]    entry_count,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ssp_pkg::VAL_W-1:0]    cfg_data
);
    import ssp_pkg::*;

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);

    typedef enum logic {
        S_IDLE,
        S_DECIDE
    } state_t;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic [VAL_W-1:0]   gap_reg;
    op_t                op_reg;
    logic [VAL_W-1:0]   v_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               done_reg;
    logic [1:0]         status_reg;
    logic [RIDX_W-1:0]  rindex_reg;
    logic [VAL_W-1:0]   rvalue_reg;

    logic               accept;
    logic [VAL_W-1:0]   req_value;

    logic [VAL_W-1:0]   cell_value [MAX_POINTS];
    logic               cell_lt    [MAX_POINTS];
    logic               cell_close [MAX_POINTS];
    logic               cell_bnd   [MAX_POINTS];
    logic               cell_hlt   [MAX_POINTS];
    logic [VAL_W-1:0]   cell_rd    [MAX_POINTS];

    logic               any_close;
    logic               move_up;
    logic [VAL_W-1:0]   rd_value;
    logic [IW-1:0]      ins_pos;

    logic               full;
    logic               bad_idx;
    logic [1:0]         status_next;
    logic [RIDX_W-1:0]  rindex_next;
    logic [VAL_W-1:0]   rvalue_next;
    logic [CW-1:0]      count_next;
    cell_cmd_t          cmd;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign req_value = position_over ? Q16_ONE : {1'b0, position};

    // Chain of point cells
    for (genvar i = 0; i < MAX_POINTS; i++)
    begin : g_cell
        logic [VAL_W-1:0] lv;
        logic             llt;
        logic [VAL_W-1:0] rv;
        logic             rlt;

        if (i == 0)
        begin : g_first
            assign lv  = '0;
            assign llt = 1'b0;
        end
        else
        begin : g_mid_l
            assign lv  = cell_value[i-1];
            assign llt = cell_lt[i-1];
        end

        if (i == MAX_POINTS - 1)
        begin : g_last
            assign rv  = '0;
            assign rlt = 1'b0;
        end
        else
        begin : g_mid_r
            assign rv  = cell_value[i+1];
            assign rlt = cell_lt[i+1];
        end

        ssp_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .clk         (clk),
            .eval        (accept),
            .eval_value  (req_value),
            .eval_idx    (entry_index),
            .count       (count_reg),
            .gap         (gap_reg),
            .cmd         (cmd),
            .left_value  (lv),
            .left_lt     (llt),
            .right_value (rv),
            .right_lt    (rlt),
            .value       (cell_value[i]),
            .lt          (cell_lt[i]),
            .close       (cell_close[i]),
            .boundary    (cell_bnd[i]),
            .hit_lt      (cell_hlt[i]),
            .read_value  (cell_rd[i])
        );
    end

    // Combine the registered cell flags
    always_comb
    begin
        any_close = 1'b0;
        move_up   = 1'b0;
        rd_value  = '0;
        ins_pos   = '0;
        for (int i = 0; i < MAX_POINTS; i++)
        begin
            any_close = any_close | cell_close[i];
            move_up   = move_up | cell_hlt[i];
            rd_value  = rd_value | cell_rd[i];
            ins_pos   = ins_pos | (cell_bnd[i] ? IW'(i) : '0);
        end
    end

    // Decide the outcome of the pending item
    always_comb
    begin
        full        = count_reg >= MAX_CNT;
        bad_idx     = XW'(idx_reg) >= XW'(count_reg);
        status_next = ST_OK;
        rindex_next = '0;
        rvalue_next = '0;
        count_next  = count_reg;
        cmd.apply   = 1'b0;
        cmd.op      = op_reg;
        cmd.move_up = move_up;
        cmd.value   = v_reg;
        if (op_reg == OP_ADD)
        begin
            if (full)
                status_next = ST_FULL;
            else if (any_close)
                status_next = ST_CLOSE;
            else
            begin
                cmd.apply   = (state_reg == S_DECIDE);
                rindex_next = RIDX_W'(ins_pos);
                count_next  = count_reg + CW'(1);
            end
        end
        else if (bad_idx)
        begin
            status_next = ST_BAD;
        end
        else
        begin
            unique case (op_reg)
                OP_REMOVE:
                begin
                    cmd.apply  = (state_reg == S_DECIDE);
                    count_next = count_reg - CW'(1);
                end
                OP_SET:
                begin
                    cmd.apply = (state_reg == S_DECIDE);
                end
                default:
                begin
                    rvalue_next = rd_value;
                end
            endcase
        end
    end

    // Sequence the item and register the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                        state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    state_reg <= S_IDLE;
                    count_reg <= count_next;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Hold request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= op_t'(op);
            v_reg   <= req_value;
            idx_reg <= entry_index;
        end
        if (state_reg == S_DECIDE)
        begin
            status_reg <= status_next;
            rindex_reg <= rindex_next;
            rvalue_reg <= rvalue_next;
        end
    end

    // Write the minimum gap register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gap_reg <= VAL_W'(7);
        else if (cfg_valid && cfg_ready)
            gap_reg <= cfg_data;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign result_index = rindex_reg;
    assign result_value = rvalue_reg;
    assign entry_count  = CNT_W'(count_reg);

    // Count never exceeds the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("point count above capacity");

    // A result strobe follows each decide cycle, with the table back in idle
    a_done_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) |=> done_reg && (state_reg == S_IDLE))
        else $error("result strobe missing after decide");

    // A full report leaves the table full
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == ST_FULL)) |-> (count_reg == MAX_CNT))
        else $error("full status with room left");

    // Count stays unchanged after an idle cycle; it moves only when an item is decided
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> $stable(count_reg))
        else $error("count changed outside decide cycle");

endmodule

>>> rtl/core/ssp_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_cell: one slot of the sorted point chain
// Holds one point, compares it against the incoming request when an item is
// accepted, and in the commit cycle keeps its point, takes the new one, or
// takes the point of its left or right neighbor.
// ----------------------------------------------------------------------------
module ssp_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 8
) (
    input  logic                       clk,
    input  logic                       eval,
    input  logic [ssp_pkg::VAL_W-1:0]  eval_value,
    input  logic [ssp_pkg::IDX_W-1:0]  eval_idx,
    input  logic [CW-1:0]              count,
    input  logic [ssp_pkg::VAL_W-1:0]  gap,
    input  ssp_pkg::cell_cmd_t         cmd,
    input  logic [ssp_pkg::VAL_W-1:0]  left_value,
    input  logic                       left_lt,
    input  logic [ssp_pkg::VAL_W-1:0]  right_value,
    input  logic                       right_lt,
    output logic [ssp_pkg::VAL_W-1:0]  value,
    output logic                       lt,
    output logic                       close,
    output logic                       boundary,
    output logic                       hit_lt,
    output logic [ssp_pkg::VAL_W-1:0]  read_value
);
    import ssp_pkg::*;

    localparam logic [31:0] MY_IDX = 32'(INDEX);
    localparam logic        FIRST  = (INDEX == 0);

    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;
    logic             lt_reg;
    logic             close_reg;
    logic             hit_reg;
    logic             ge_reg;
    logic [VAL_W-1:0] rd_reg;

    logic             valid;
    logic             hit;
    logic [VAL_W-1:0] delta;

    // Compare the stored point against the request
    always_comb
    begin
        valid = MY_IDX < 32'(count);
        hit   = MY_IDX == 32'(eval_idx);
        delta = (value_reg > eval_value) ? (value_reg - eval_value)
                                         : (eval_value - value_reg);
    end

    // Capture per-cell flags when an item is accepted
    always_ff @(posedge clk)
    begin
        if (eval)
        begin
            lt_reg    <= valid && (value_reg < eval_value);
            close_reg <= valid && (delta < gap);
            hit_reg   <= hit;
            ge_reg    <= MY_IDX >= 32'(eval_idx);
            rd_reg    <= (valid && hit) ? value_reg : '0;
        end
    end

    // Pick the next point from self, request or neighbors
    always_comb
    begin
        value_next = value_reg;
        case (cmd.op)
            OP_ADD:
            begin
                if (!lt_reg)
                    value_next = (FIRST || left_lt) ? cmd.value : left_value;
            end
            OP_REMOVE:
            begin
                if (ge_reg)
                    value_next = right_value;
            end
            OP_SET:
            begin
                if (cmd.move_up)
                begin
                    if (ge_reg)
                    begin
                        if (right_lt)
                            value_next = right_value;
                        else if (lt_reg)
                            value_next = cmd.value;
                    end
                end
                else if (!lt_reg && (!ge_reg || hit_reg))
                begin
                    value_next = (FIRST || left_lt) ? cmd.value : left_value;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // Hold or update the stored point
    always_ff @(posedge clk)
    begin
        if (cmd.apply)
            value_reg <= value_next;
    end

    assign value      = value_reg;
    assign lt         = lt_reg;
    assign close      = close_reg;
    assign boundary   = !lt_reg && (FIRST || left_lt);
    assign hit_lt     = hit_reg && lt_reg;
    assign read_value = rd_reg;

endmodule
